// ===== src/sfvi_pkg.sv =====
// sfvi_pkg: shared constants and types for the table interpolation block
// used by the serial divider and the top level; no dependencies
package sfvi_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;

  localparam int VOLT_W     = 16;
  localparam int INDEX_W    = 5;
  localparam int LEVEL_W    = 8;
  localparam int DIVIDEND_W = 24;
  localparam int DIVISOR_W  = 16;
  localparam int QUOT_W     = 8;
  localparam int DIV_CNT_W  = $clog2(QUOT_W + 1);

  localparam logic [LEVEL_W-1:0] FULL_LEVEL  = 8'd255;
  localparam logic [LEVEL_W-1:0] EMPTY_LEVEL = 8'd0;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/sfvi_div.sv =====
// sfvi_div: bit-serial restoring divider, one quotient bit per cycle
// the quotient must fit in QUOT_W bits; depends on sfvi_pkg
module sfvi_div import sfvi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIVIDEND_W-1:0] rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] den_r, den_nxt;
  logic [QUOT_W-1:0]     quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic                  fits;

  assign fits = (rem_r >= den_r);

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (cnt_r != '0) begin
      if (fits) begin
        rem_nxt = rem_r - den_r;
      end
      quo_nxt  = {quo_r[QUOT_W-2:0], fits};
      den_nxt  = {1'b0, den_r[DIVIDEND_W-1:1]};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end else if (req.start) begin
      rem_nxt = req.dividend;
      den_nxt = {{(DIVIDEND_W-DIVISOR_W-QUOT_W+1){1'b0}}, req.divisor, {(QUOT_W-1){1'b0}}};
      cnt_nxt = DIV_CNT_W'(QUOT_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== src/soc_from_voltage_interp.sv =====
// soc_from_voltage_interp: state of charge from cell voltage by table interpolation
// holds the voltage table memory and the search sequencer; uses sfvi_pkg and sfvi_div
// load: written while idle, busy stays low; convert: busy high until the last-entry check
// if above the last entry, the first-entry check if at or below the first, else through the
// one-read-per-cycle scan for segment k (1..TABLE_ENTRIES-1) and two 8-bit serial divisions
// strobe in the cycle busy falls; no receiver stall; reset clears control, table undefined
module soc_from_voltage_interp import sfvi_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_req_type,
  input  logic [INDEX_W-1:0]        in_entry_index,
  input  logic signed [VOLT_W-1:0]  in_entry_voltage,
  input  logic signed [VOLT_W-1:0]  in_cell_voltage,
  output logic                      out_strobe,
  output logic [LEVEL_W-1:0]        out_charge_level
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0]        LAST_ADDR = AW'(TABLE_ENTRIES - 1);
  localparam logic [DIVISOR_W-1:0] SEG_COUNT = DIVISOR_W'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LAST  = 3'd1;
  localparam logic [2:0] S_FIRST = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DIV1  = 3'd4;
  localparam logic [2:0] S_DIV2  = 3'd5;

  logic [2:0]               state_r, state_nxt;
  logic [AW-1:0]            addr_r, addr_nxt;
  logic [AW-1:0]            k_r, k_nxt;
  logic signed [VOLT_W-1:0] v_r, v_nxt;
  logic signed [VOLT_W-1:0] prev_r, prev_nxt;
  logic                     out_strobe_r, out_strobe_nxt;
  logic [LEVEL_W-1:0]       level_r, level_nxt;

  logic signed [VOLT_W-1:0] mem_r [TABLE_ENTRIES];
  logic signed [VOLT_W-1:0] rd_data_r;
  logic                     load_we;
  logic [AW-1:0]            wr_addr;

  logic signed [VOLT_W:0]   span_w, offset_w;
  logic [DIVIDEND_W-1:0]    seg_scaled;
  logic [LEVEL_W-1:0]       km1;
  logic [15:0]              acc;

  div_req_t div_req;
  div_rsp_t div_rsp;

  sfvi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign wr_addr  = AW'(in_entry_index);
  assign span_w   = {rd_data_r[VOLT_W-1], rd_data_r} - {prev_r[VOLT_W-1], prev_r};
  assign offset_w = {v_r[VOLT_W-1], v_r} - {prev_r[VOLT_W-1], prev_r};
  // offset * 255
  assign seg_scaled = {offset_w[VOLT_W-1:0], 8'b0} - {8'b0, offset_w[VOLT_W-1:0]};
  assign km1 = LEVEL_W'(k_r) - 1'b1;
  assign acc = ({km1, 8'b0} - {8'b0, km1}) + {8'b0, div_rsp.quotient};

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    k_nxt          = k_r;
    v_nxt          = v_r;
    prev_nxt       = prev_r;
    out_strobe_nxt = 1'b0;
    level_nxt      = level_r;
    load_we        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = seg_scaled;
    div_req.divisor  = span_w[VOLT_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_req_type == REQ_LOAD) begin
            load_we = (32'(in_entry_index) < TABLE_ENTRIES);
          end else begin
            v_nxt     = in_cell_voltage;
            addr_nxt  = LAST_ADDR;
            state_nxt = S_LAST;
          end
        end
      end
      S_LAST: begin
        if (v_r > rd_data_r) begin
          out_strobe_nxt = 1'b1;
          level_nxt      = FULL_LEVEL;
          state_nxt      = S_IDLE;
        end else begin
          addr_nxt  = '0;
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        if (v_r <= rd_data_r) begin
          out_strobe_nxt = 1'b1;
          level_nxt      = EMPTY_LEVEL;
          state_nxt      = S_IDLE;
        end else begin
          prev_nxt  = rd_data_r;
          addr_nxt  = AW'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_data_r >= v_r || addr_r == LAST_ADDR) begin
          k_nxt         = addr_r;
          div_req.start = 1'b1;
          state_nxt     = S_DIV1;
        end else begin
          prev_nxt = rd_data_r;
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_DIV1: begin
        div_req.dividend = DIVIDEND_W'(acc);
        div_req.divisor  = SEG_COUNT;
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          out_strobe_nxt = 1'b1;
          level_nxt      = div_rsp.quotient;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // table memory, registered read at the next scan address
  always_ff @(posedge clk) begin
    if (load_we) begin
      mem_r[wr_addr] <= in_entry_voltage;
    end
    rd_data_r <= mem_r[addr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      addr_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    k_r     <= k_nxt;
    v_r     <= v_nxt;
    prev_r  <= prev_nxt;
    level_r <= level_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_charge_level = level_r;

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> ($past(state_r) == S_LAST || $past(state_r) == S_FIRST ||
                      $past(state_r) == S_DIV2))
    else $error("result strobe without a finishing state");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (state_r == S_IDLE))
    else $error("result strobe while a transaction is still in progress");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (addr_r != '0 && 32'(addr_r) < TABLE_ENTRIES))
    else $error("table scan address out of range");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV1 || state_r == S_DIV2))
    else $error("divider finished outside a divide state");

endmodule

// ===== verif/soc_from_voltage_interp_tb.sv =====
// testbench for soc_from_voltage_interp: loads voltage tables, converts voltages and
// checks each charge level against an in-bench interpolation predictor
// depends on sfvi_pkg and the soc_from_voltage_interp top level
`timescale 1ns / 100ps

module soc_from_voltage_interp_tb;
  import sfvi_pkg::*;

  localparam int TABLE_N        = TABLE_ENTRIES_DEF;
  localparam int LEVEL_SPAN     = 255;
  localparam int DRAIN_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 60;

  typedef enum int {
    TBL_EVEN_WIDE,
    TBL_EVEN_NARROW,
    TBL_RANDOM_WIDE,
    TBL_NARROW,
    TBL_PLATEAU,
    TBL_UNSORTED,
    TBL_EXTREME
  } table_shape_t;

  typedef struct {
    logic                     req_type;
    logic [INDEX_W-1:0]       entry_index;
    logic signed [VOLT_W-1:0] entry_voltage;
    logic signed [VOLT_W-1:0] cell_voltage;
    int                       gap;
  } soc_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_req_type = REQ_LOAD;
  logic [INDEX_W-1:0] in_entry_index = '0;
  logic signed [VOLT_W-1:0] in_entry_voltage = '0;
  logic signed [VOLT_W-1:0] in_cell_voltage = '0;
  logic out_strobe;
  logic [LEVEL_W-1:0] out_charge_level;

  soc_item_t pending_items[$];
  logic [LEVEL_W-1:0] level_expected[$];
  logic signed [VOLT_W-1:0] soc_table[TABLE_N];
  int plan_table[TABLE_N];
  int mismatch_count = 0;
  int idle_cycles = 0;
  int gap_left = 0;

  soc_item_t next_item;
  int gap_now;
  logic fire;
  logic [LEVEL_W-1:0] level_exp;

  always #1 clk = ~clk;

  soc_from_voltage_interp #(
    .TABLE_ENTRIES(TABLE_N)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_entry_index   (in_entry_index),
    .in_entry_voltage (in_entry_voltage),
    .in_cell_voltage  (in_cell_voltage),
    .out_strobe       (out_strobe),
    .out_charge_level (out_charge_level)
  );

  function automatic logic [LEVEL_W-1:0] interp_level(logic signed [VOLT_W-1:0] v);
    int k;
    int span;
    int offset;
    int acc;
    if (v > soc_table[TABLE_N-1]) return FULL_LEVEL;
    if (v <= soc_table[0]) return EMPTY_LEVEL;
    k = 1;
    while (k < TABLE_N - 1 && soc_table[k] < v) k++;
    span   = int'(soc_table[k]) - int'(soc_table[k-1]);
    offset = int'(v) - int'(soc_table[k-1]);
    acc    = (k - 1) * LEVEL_SPAN + (offset * LEVEL_SPAN) / span;
    return LEVEL_W'(acc / (TABLE_N - 1));
  endfunction

  function automatic logic signed [VOLT_W-1:0] sat_volt(int x);
    if (x > 32767) return 16'sh7fff;
    if (x < -32768) return 16'sh8000;
    return VOLT_W'(x);
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic push_load(int idx, int val, int gap);
    soc_item_t it;
    it.req_type      = REQ_LOAD;
    it.entry_index   = INDEX_W'(idx);
    it.entry_voltage = sat_volt(val);
    it.cell_voltage  = VOLT_W'($urandom);
    it.gap           = gap;
    plan_table[idx]  = int'(it.entry_voltage);
    pending_items.push_back(it);
  endtask

  task automatic push_convert(int val, int gap);
    soc_item_t it;
    it.req_type      = REQ_CONVERT;
    it.entry_index   = INDEX_W'($urandom);
    it.entry_voltage = VOLT_W'($urandom);
    it.cell_voltage  = sat_volt(val);
    it.gap           = gap;
    pending_items.push_back(it);
  endtask

  task automatic load_table(table_shape_t shape, bit quiet);
    int vals[TABLE_N];
    int prev;
    int i;
    bit down;
    case (shape)
      TBL_EVEN_WIDE: begin
        for (i = 0; i < TABLE_N; i++) vals[i] = -32768 + (i * 65535) / (TABLE_N - 1);
      end
      TBL_EVEN_NARROW: begin
        for (i = 0; i < TABLE_N; i++) vals[i] = 2000 + (i * 800) / (TABLE_N - 1);
      end
      TBL_UNSORTED: begin
        for (i = 0; i < TABLE_N; i++) vals[i] = int'(sat_volt(int'($urandom_range(0, 65535))
                                                 - 32768));
      end
      default: begin
        case (shape)
          TBL_NARROW:  prev = 1990 + $urandom_range(0, 40);
          TBL_PLATEAU: prev = -20000 + $urandom_range(0, 20000);
          TBL_EXTREME: prev = -32768;
          default:     prev = -32768 + $urandom_range(0, 2000);
        endcase
        for (i = 0; i < TABLE_N; i++) begin
          vals[i] = prev;
          case (shape)
            TBL_NARROW:  prev += $urandom_range(0, 30);
            TBL_PLATEAU: prev += ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 500);
            default:     prev += $urandom_range(0, 2200);
          endcase
          if (prev > 32767) prev = 32767;
        end
        if (shape == TBL_EXTREME) vals[TABLE_N-1] = 32767;
      end
    endcase
    down = $urandom_range(0, 1);
    for (i = 0; i < TABLE_N; i++) begin
      if (down) push_load(TABLE_N - 1 - i, vals[TABLE_N - 1 - i], pick_gap(quiet));
      else push_load(i, vals[i], pick_gap(quiet));
    end
  endtask

  // driver: one transaction per accepted start, gaps taken from the item
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      fire = start && !busy;
      if (fire) begin
        if (in_req_type == REQ_LOAD) begin
          if (int'(in_entry_index) < TABLE_N) soc_table[in_entry_index] = in_entry_voltage;
        end else begin
          level_expected.push_back(interp_level(in_cell_voltage));
        end
      end
      if (fire || !start) begin
        gap_now = fire ? next_item.gap : gap_left;
        if (gap_now > 0) begin
          start    <= 1'b0;
          gap_left <= gap_now - 1;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          in_req_type      <= next_item.req_type;
          in_entry_index   <= next_item.entry_index;
          in_entry_voltage <= next_item.entry_voltage;
          in_cell_voltage  <= next_item.cell_voltage;
          start    <= 1'b1;
          gap_left <= 0;
        end else begin
          start    <= 1'b0;
          gap_left <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (level_expected.size() == 0) begin
        $error("charge_level: expected none, actual %0d", out_charge_level);
        mismatch_count++;
      end else begin
        level_exp = level_expected.pop_front();
        if (out_charge_level !== level_exp) begin
          $error("charge_level: expected %0d, actual %0d", level_exp, out_charge_level);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int p;
    int n;
    int r;
    int j;
    int lo;
    int hi;
    int v;
    bit quiet;

    // directed: evenly spaced full-range table
    load_table(TBL_EVEN_WIDE, 1'b0);
    push_convert(-32768, 0);
    push_convert(-32767, 1);
    push_convert(plan_table[5] - 1, 0);
    push_convert(plan_table[5], 0);
    push_convert(plan_table[5] + 1, 2);
    push_convert(0, 0);
    push_convert(32766, 0);
    push_convert(32767, 0);
    // narrow table, voltages around and beyond its ends
    load_table(TBL_EVEN_NARROW, 1'b0);
    push_convert(1999, 0);
    push_convert(2000, 0);
    push_convert(2001, 0);
    push_convert(2400, 3);
    push_convert(2799, 0);
    push_convert(2800, 0);
    push_convert(2801, 0);
    push_convert(-32768, 0);
    push_convert(32767, 0);
    // flat segment
    push_load(10, plan_table[9], 0);
    push_convert(plan_table[9], 0);
    push_convert(plan_table[9] + 1, 0);

    for (p = 0; p < PHASES; p++) begin
      quiet = (p % 4 == 3);
      load_table(table_shape_t'(int'(TBL_RANDOM_WIDE) + p % 5), quiet);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        j = $urandom_range(0, TABLE_N - 1);
        if (r < 10) begin
          if ($urandom_range(0, 1) == 1) v = plan_table[j] + $urandom_range(0, 60) - 30;
          else v = int'($urandom_range(0, 65535)) - 32768;
          push_load(j, v, pick_gap(quiet));
        end else begin
          r = $urandom_range(0, 99);
          if (r < 35) begin
            v = plan_table[j] + $urandom_range(0, 4) - 2;
          end else if (r < 55) begin
            v = plan_table[j];
          end else if (r < 80) begin
            lo = plan_table[0] - 50;
            hi = plan_table[TABLE_N-1] + 50;
            if (lo > hi) begin
              lo = hi;
              hi = plan_table[0] - 50;
            end
            v = lo + $urandom_range(0, hi - lo);
          end else if (r < 92) begin
            v = int'($urandom_range(0, 65535)) - 32768;
          end else begin
            v = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
          end
          push_convert(v, pick_gap(quiet));
        end
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_items.size() != 0 || start || level_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
